@@ rtl/cbu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbu_pkg: shared types and constants of the packed canvas blitter
// Action, raster mode, status and CSR index codes, field widths, multiply request type.
// ----------------------------------------------------------------------------
package cbu_pkg;

   localparam int STORE_BYTES_DEF = 65536;
   localparam int WORD_BITS_DEF   = 32;

   // bit address: (1024*1023 + 1023) * 32 fits in 25 bits
   localparam int POS_W  = 26;
   // bits left in one run: up to 1024 pixels * 32 bits
   localparam int LEFT_W = 17;
   // run size in bits: up to 32 at the default word
   localparam int NB_W   = 7;

   localparam int MAC_A_W = 22;
   localparam int MAC_C_W = 10;
   localparam int MAC_B_W = 11;

   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;
   localparam logic [1:0] ACT_BLIT  = 2'd3;

   localparam logic [1:0] MODE_COPY = 2'd0;
   localparam logic [1:0] MODE_OR   = 2'd1;
   localparam logic [1:0] MODE_XOR  = 2'd2;
   localparam logic [1:0] MODE_AND  = 2'd3;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_BPP    = 2'd2;

   // (a + c) * b
   typedef struct packed {
      logic [MAC_A_W-1:0] a;
      logic [MAC_C_W-1:0] c;
      logic [MAC_B_W-1:0] b;
   } mac_req_type;

endpackage

@@ rtl/packed_canvas_blitter_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_canvas_blitter_unit: packed-pixel canvas with pixel access and blit
// Write/read pixel, clipped rectangle clear and raster-op run blit.
// ----------------------------------------------------------------------------
// One beat at a time: req_stall is high from acceptance until the result beat
// is loaded into the output register. An action first passes the states M1 to
// M3 of the shared multiplier ((width*row + x) * bpp), then walks the canvas
// byte by byte (store read, then modify and write), then loads the result in
// the done state, which waits while an earlier result stalls. A pixel write or
// read touches 1 to 5 bytes. A blit first sizes its run against the word, one
// pixel per cycle, then walks its 1 to WORD_BITS/8 + 1 bytes (5 at the default
// word). A clear repeats per clipped row the multiplier states, with M4 for
// the row length, and the byte walk. An origin off the canvas, an empty clear
// or an empty blit run goes straight to the done state. The result register
// lets the next beat be accepted while a result still waits.
// ----------------------------------------------------------------------------
module packed_canvas_blitter_unit #(
   parameter int STORE_BYTES = cbu_pkg::STORE_BYTES_DEF,
   parameter int WORD_BITS   = cbu_pkg::WORD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [9:0]  req_x,
   input  logic [9:0]  req_y,
   input  logic [10:0] req_rect_width,
   input  logic [10:0] req_rect_height,
   input  logic [31:0] req_source_bits,
   input  logic [1:0]  req_raster_mode,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_value,
   output logic        rsp_status,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_write_data
);

   localparam int ADDR_W = $clog2(STORE_BYTES);
   localparam int POS_W  = cbu_pkg::POS_W;
   localparam int LEFT_W = cbu_pkg::LEFT_W;
   localparam int NB_W   = cbu_pkg::NB_W;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CNT  = 4'd1;  // size blit run
   localparam logic [3:0] S_M1   = 4'd2;  // row * width
   localparam logic [3:0] S_M2   = 4'd3;  // (. + x) * bpp
   localparam logic [3:0] S_M3   = 4'd4;  // take pos; clear: w * bpp
   localparam logic [3:0] S_M4   = 4'd5;  // clear: take row length
   localparam logic [3:0] S_RD   = 4'd6;  // issue byte read
   localparam logic [3:0] S_WR   = 4'd7;  // modify, write (not on read), advance
   localparam logic [3:0] S_DONE = 4'd8;

   // configuration
   logic [10:0] width_ff, width_in;
   logic [10:0] height_ff, height_in;
   logic [5:0]  bpp_cfg_ff, bpp_cfg_in;
   logic [5:0]  bpp;

   // sequencer and item state
   logic [3:0]        state_ff, state_in;
   logic [1:0]        action_ff, action_in;
   logic [1:0]        mode_ff, mode_in;
   logic [9:0]        x_ff, x_in;
   logic [9:0]        row_ff, row_in;
   logic [10:0]       row_end_ff, row_end_in;
   logic [10:0]       wclip_ff, wclip_in;
   logic [10:0]       n_ff, n_in;
   logic [10:0]       cnt_ff, cnt_in;
   logic [NB_W-1:0]   nb_ff, nb_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [LEFT_W-1:0] left_ff, left_in;
   logic [31:0]       src_ff, src_in;
   logic [31:0]       acc_ff, acc_in;
   logic              status_ff, status_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_read_value_ff, rsp_read_value_in;
   logic        rsp_status_ff, rsp_status_in;

   // shared multiplier and store
   cbu_pkg::mac_req_type mac_req;
   logic [POS_W-1:0]     mac_prod;
   logic                 st_wr_en;
   logic                 st_rd_en;
   logic [ADDR_W-1:0]    st_addr;
   logic [7:0]           st_wdata;
   logic [7:0]           st_rdata;

   // per-item decode at acceptance
   logic        accept;
   logic        oob;
   logic [10:0] avail_w, avail_h, wclip, hclip;

   // byte step
   logic [2:0]        bitp;
   logic [3:0]        avail;
   logic [3:0]        cur;
   logic [3:0]        shamt;
   logic [8:0]        lmask9;
   logic [7:0]        lmask;
   logic [7:0]        bmask;
   logic [7:0]        old;
   logic [LEFT_W-1:0] rem;
   logic [31:0]       src_sh;
   logic [7:0]        chunk;
   logic [7:0]        newc;
   logic [7:0]        wr_byte;

   // blit sizing
   logic [7:0]  nb_sum;
   logic        cnt_more;

   assign bpp = (bpp_cfg_ff == 6'd0) ? 6'd1 :
                (bpp_cfg_ff > 6'd32) ? 6'd32 : bpp_cfg_ff;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   assign oob     = ({1'b0, req_x} >= width_ff) || ({1'b0, req_y} >= height_ff);
   assign avail_w = width_ff - {1'b0, req_x};
   assign avail_h = height_ff - {1'b0, req_y};
   assign wclip   = (req_rect_width > avail_w) ? avail_w : req_rect_width;
   assign hclip   = (req_rect_height > avail_h) ? avail_h : req_rect_height;

   assign nb_sum   = 8'(nb_ff) + {2'b00, bpp};
   assign cnt_more = (cnt_ff < n_ff) && (nb_sum <= 8'(WORD_BITS));

   // byte step: bits of this byte covered by the run, MSB first
   assign bitp   = pos_ff[2:0];
   assign avail  = 4'd8 - {1'b0, bitp};
   assign cur    = (left_ff < LEFT_W'(avail)) ? left_ff[3:0] : avail;
   assign shamt  = avail - cur;
   assign lmask9 = (9'd1 << cur) - 9'd1;
   assign lmask  = lmask9[7:0];
   assign bmask  = lmask << shamt[2:0];
   assign old    = (st_rdata >> shamt[2:0]) & lmask;
   assign rem    = left_ff - LEFT_W'(cur);
   assign src_sh = (rem >= LEFT_W'(32)) ? 32'd0 : (src_ff >> rem[4:0]);
   assign chunk  = src_sh[7:0] & lmask;

   always_comb begin
      newc = chunk;
      if (action_ff == cbu_pkg::ACT_BLIT) begin
         case (mode_ff)
            cbu_pkg::MODE_COPY: newc = chunk;
            cbu_pkg::MODE_OR:   newc = chunk | old;
            cbu_pkg::MODE_XOR:  newc = chunk ^ old;
            cbu_pkg::MODE_AND:  newc = chunk & old;
            default:            newc = chunk;
         endcase
      end
   end

   assign wr_byte = (st_rdata & ~bmask) | (newc << shamt[2:0]);

   // multiplier operand selection
   always_comb begin
      mac_req = '0;
      case (state_ff)
         S_M1: begin
            mac_req.a = cbu_pkg::MAC_A_W'(row_ff);
            mac_req.b = width_ff;
         end
         S_M2: begin
            mac_req.a = mac_prod[cbu_pkg::MAC_A_W-1:0];
            mac_req.c = x_ff;
            mac_req.b = cbu_pkg::MAC_B_W'(bpp);
         end
         S_M3: begin
            mac_req.a = cbu_pkg::MAC_A_W'(wclip_ff);
            mac_req.b = cbu_pkg::MAC_B_W'(bpp);
         end
         default: begin
            mac_req = '0;
         end
      endcase
   end

   assign st_addr  = pos_ff[ADDR_W+2:3];
   assign st_rd_en = (state_ff == S_RD);
   assign st_wr_en = (state_ff == S_WR) && (action_ff != cbu_pkg::ACT_READ);
   assign st_wdata = wr_byte;

   cbu_mac u_mac (
      .clock   (clock),
      .req     (mac_req),
      .prod_ff (mac_prod)
   );

   cbu_store #(
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock      (clock),
      .wr_en      (st_wr_en),
      .wr_addr    (st_addr),
      .wr_data    (st_wdata),
      .rd_en      (st_rd_en),
      .rd_addr    (st_addr),
      .rd_data_ff (st_rdata)
   );

   // configuration writes
   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      bpp_cfg_in = bpp_cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            cbu_pkg::CSR_WIDTH:  width_in   = csr_write_data;
            cbu_pkg::CSR_HEIGHT: height_in  = csr_write_data;
            cbu_pkg::CSR_BPP:    bpp_cfg_in = csr_write_data[5:0];
            default:             width_in   = width_ff;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in          = state_ff;
      action_in         = action_ff;
      mode_in           = mode_ff;
      x_in              = x_ff;
      row_in            = row_ff;
      row_end_in        = row_end_ff;
      wclip_in          = wclip_ff;
      n_in              = n_ff;
      cnt_in            = cnt_ff;
      nb_in             = nb_ff;
      pos_in            = pos_ff;
      left_in           = left_ff;
      src_in            = src_ff;
      acc_in            = acc_ff;
      status_in         = status_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_read_value_in = rsp_read_value_ff;
      rsp_status_in     = rsp_status_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               action_in  = req_action;
               mode_in    = req_raster_mode;
               x_in       = req_x;
               row_in     = req_y;
               wclip_in   = wclip;
               row_end_in = {1'b0, req_y} + hclip;
               n_in       = wclip;
               cnt_in     = '0;
               acc_in     = '0;
               status_in  = cbu_pkg::STATUS_OK;
               src_in     = req_source_bits;
               nb_in      = NB_W'(bpp);
               if (oob) begin
                  status_in = cbu_pkg::STATUS_RANGE;
                  state_in  = S_DONE;
               end else begin
                  case (req_action)
                     cbu_pkg::ACT_WRITE: state_in = S_M1;
                     cbu_pkg::ACT_READ:  state_in = S_M1;
                     cbu_pkg::ACT_CLEAR: begin
                        src_in = '0;
                        if (wclip == 11'd0 || hclip == 11'd0) begin
                           state_in = S_DONE;
                        end else begin
                           state_in = S_M1;
                        end
                     end
                     cbu_pkg::ACT_BLIT: begin
                        nb_in    = '0;
                        state_in = S_CNT;
                     end
                     default: state_in = S_DONE;
                  endcase
               end
            end
         end
         S_CNT: begin
            if (cnt_more) begin
               nb_in  = nb_sum[NB_W-1:0];
               cnt_in = cnt_ff + 11'd1;
            end else if (nb_ff == '0) begin
               state_in = S_DONE;
            end else begin
               state_in = S_M1;
            end
         end
         S_M1: state_in = S_M2;
         S_M2: state_in = S_M3;
         S_M3: begin
            pos_in = mac_prod;
            if (action_ff == cbu_pkg::ACT_CLEAR) begin
               state_in = S_M4;
            end else begin
               left_in  = LEFT_W'(nb_ff);
               state_in = S_RD;
            end
         end
         S_M4: begin
            left_in  = mac_prod[LEFT_W-1:0];
            state_in = S_RD;
         end
         S_RD: state_in = S_WR;
         S_WR: begin
            acc_in  = (acc_ff << cur) | {24'd0, old};
            pos_in  = pos_ff + POS_W'(cur);
            left_in = rem;
            if (rem != '0) begin
               state_in = S_RD;
            end else if (action_ff == cbu_pkg::ACT_CLEAR &&
                         ({1'b0, row_ff} + 11'd1) < row_end_ff) begin
               row_in   = row_ff + 10'd1;
               state_in = S_M1;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_status_in     = status_ff;
               rsp_read_value_in = (action_ff == cbu_pkg::ACT_READ &&
                                    status_ff == cbu_pkg::STATUS_OK) ? acc_ff : 32'd0;
               state_in          = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= 11'd128;
         height_ff    <= 11'd64;
         bpp_cfg_ff   <= 6'd1;
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         bpp_cfg_ff   <= bpp_cfg_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff         <= action_in;
      mode_ff           <= mode_in;
      x_ff              <= x_in;
      row_ff            <= row_in;
      row_end_ff        <= row_end_in;
      wclip_ff          <= wclip_in;
      n_ff              <= n_in;
      cnt_ff            <= cnt_in;
      nb_ff             <= nb_in;
      pos_ff            <= pos_in;
      left_ff           <= left_in;
      src_ff            <= src_in;
      acc_ff            <= acc_in;
      status_ff         <= status_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_status_ff     <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;

   // a new result is only loaded out of the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_DONE))
      else $error("result loaded outside done state");

   // an error result never carries read data
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == cbu_pkg::STATUS_RANGE) |-> (rsp_read_value == 32'd0))
      else $error("error result with nonzero read value");

   // every byte step consumes at least one bit
   a_step_progress: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WR) |-> (cur != 4'd0))
      else $error("byte step with empty run");

   // the store is only written in the write step
   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      st_wr_en |-> $past(state_ff == S_RD))
      else $error("store write without preceding read");

endmodule

@@ rtl/cbu_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbu_store: canvas byte store
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module cbu_store #(
   parameter int ADDR_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data_ff
);

   logic [7:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

@@ rtl/cbu_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbu_mac: shared address multiplier
// Registered (a + c) * b, used for row offset, bit address and row length.
// ----------------------------------------------------------------------------
module cbu_mac (
   input  logic                      clock,
   input  cbu_pkg::mac_req_type      req,
   output logic [cbu_pkg::POS_W-1:0] prod_ff
);

   logic [cbu_pkg::MAC_A_W-1:0]                  sum;
   logic [cbu_pkg::MAC_A_W+cbu_pkg::MAC_B_W-1:0] prod_full;

   assign sum       = req.a + cbu_pkg::MAC_A_W'(req.c);
   assign prod_full = sum * req.b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_full[cbu_pkg::POS_W-1:0];
   end

endmodule
